[rtl/core/mandelbrot_escape_iteration_assert.svh]
// Assertion macros for the Mandelbrot escape-time block.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef MANDELBROT_ESCAPE_ITERATION_ASSERT_SVH
`define MANDELBROT_ESCAPE_ITERATION_ASSERT_SVH

// Condition in this cycle implies a check in the same cycle
`define MBE_ASSERT_NOW(label, cond, check) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error("mandelbrot escape block: same-cycle check failed");

// Condition in this cycle implies a check in the next cycle
`define MBE_ASSERT_NEXT(label, cond, check) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error("mandelbrot escape block: next-cycle check failed");

`endif

[rtl/core/mbe_pkg.sv]
// Shared types and constants of the Mandelbrot escape-time block.
// No dependencies; imported by every module of the block.
package mbe_pkg;

  // Fixed field widths
  localparam int unsigned PIX_W   = 10;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned BAIL_W  = 14;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned Q28     = 28;
  localparam int unsigned INT_W   = 16;
  localparam int unsigned STEP_W  = 31;
  localparam int unsigned Q_DEPTH = 4;

  // Register reset values
  localparam logic signed [31:0]   X_ORIGIN_RST   = -32'sd805306368;
  localparam logic [STEP_W-1:0]    X_STEP_RST     = 31'd1074823;
  localparam logic signed [31:0]   Y_ORIGIN_RST   = -32'sd536870912;
  localparam logic [STEP_W-1:0]    Y_STEP_RST     = 31'd1074823;
  localparam logic [COUNT_W-1:0]   MAX_ITER_RST   = 16'd100;
  localparam logic [BAIL_W-1:0]    BAILOUT_SQ_RST = 14'd10000;

  // Register indexes of the configuration port
  typedef enum logic [CIDX_W-1:0] {
    REG_X_ORIGIN   = 3'd0,
    REG_X_STEP     = 3'd1,
    REG_Y_ORIGIN   = 3'd2,
    REG_Y_STEP     = 3'd3,
    REG_MAX_ITER   = 3'd4,
    REG_BAILOUT_SQ = 3'd5
  } cfg_reg_t;

  // Configuration register set
  typedef struct packed {
    logic signed [31:0]  x_origin;
    logic [STEP_W-1:0]   x_step;
    logic signed [31:0]  y_origin;
    logic [STEP_W-1:0]   y_step;
    logic [COUNT_W-1:0]  max_iter;
    logic [BAIL_W-1:0]   bailout_sq;
  } cfg_t;

  // Pixel indices carried with an item
  typedef struct packed {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
  } pix_t;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Iteration sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_NEXT,
    S_MAG,
    S_MUL,
    S_MID,
    S_PROD,
    S_DONE
  } iter_state_t;

endpackage

[rtl/core/mandelbrot_escape_iteration.sv]
// Mandelbrot escape-time counter, top level.
// Input channel: in_valid/in_stall with pixel_col and pixel_row; an item is taken
// at a clock edge with in_valid high and in_stall low. Output channel: out_valid/
// out_stall with iter_count, out_col and out_row, one result item per input item,
// in input order. Configuration: cfg_write, cfg_index, cfg_data write one register
// per cycle; write only while no item is in flight.
// Flow: an accepted item passes the front stages before it reaches the queue. In the
// iteration unit each iteration passes six registered steps (scale and add c,
// magnitude, partial products, middle sums, product assembly, squared-magnitude test);
// the loop ends when the point escapes or the count reaches max_iter (2 or more).
// A max_iter of 0 or 1 skips the iteration and gives a count of 1.
// One item is iterated at a time: the unit takes no new item before the last result
// is loaded; up to four more wait in the queue and two in the front stages.
// Reset (rst, synchronous) empties the pipeline and queue and loads the default
// view. When out_stall is high the result register holds; the iteration unit may
// finish the next item and wait; in_stall rises once the queue and front stages are full.
// Depends on mbe_pkg, mbe_front, mbe_queue, mbe_iter and the assertion header.
`include "mandelbrot_escape_iteration_assert.svh"

module mandelbrot_escape_iteration #(
  parameter int IMAGE_SIZE = 1024,
  parameter int FRAC_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [mbe_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [mbe_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mbe_pkg::PIX_W-1:0]    pixel_col,
  input  logic [mbe_pkg::PIX_W-1:0]    pixel_row,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mbe_pkg::COUNT_W-1:0]  iter_count,
  output logic [mbe_pkg::PIX_W-1:0]    out_col,
  output logic [mbe_pkg::PIX_W-1:0]    out_row
);
  import mbe_pkg::*;

  localparam int W  = INT_W + FRAC_BITS;
  localparam int DW = 2 * W + $bits(pix_t);

  cfg_t                cfg;
  q_stat_t             q_stat;
  logic                q_push, q_pop;
  logic signed [W-1:0] push_cx, push_cy, pop_cx, pop_cy;
  pix_t                push_pix, pop_pix;
  logic [DW-1:0]       push_data, pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin   <= X_ORIGIN_RST;
      cfg.x_step     <= X_STEP_RST;
      cfg.y_origin   <= Y_ORIGIN_RST;
      cfg.y_step     <= Y_STEP_RST;
      cfg.max_iter   <= MAX_ITER_RST;
      cfg.bailout_sq <= BAILOUT_SQ_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_X_ORIGIN:   cfg.x_origin   <= $signed(cfg_data);
        REG_X_STEP:     cfg.x_step     <= cfg_data[STEP_W-1:0];
        REG_Y_ORIGIN:   cfg.y_origin   <= $signed(cfg_data);
        REG_Y_STEP:     cfg.y_step     <= cfg_data[STEP_W-1:0];
        REG_MAX_ITER:   cfg.max_iter   <= cfg_data[COUNT_W-1:0];
        REG_BAILOUT_SQ: cfg.bailout_sq <= cfg_data[BAIL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mbe_front #(
    .IMAGE_SIZE (IMAGE_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .push_cx   (push_cx),
    .push_cy   (push_cy),
    .push_pix  (push_pix)
  );

  // Pack and unpack queue entries
  assign push_data = {push_cx, push_cy, push_pix};
  assign pop_cx    = pop_data[DW-1 -: W];
  assign pop_cy    = pop_data[DW-W-1 -: W];
  assign pop_pix   = pop_data[$bits(pix_t)-1:0];

  mbe_queue #(
    .DEPTH (Q_DEPTH),
    .DW    (DW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  mbe_iter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .pop_cx     (pop_cx),
    .pop_cy     (pop_cy),
    .pop_pix    (pop_pix),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .iter_count (iter_count),
    .out_col    (out_col),
    .out_row    (out_row)
  );

  // Queue never overflows or underflows, a pop leaves it with room, and counts stay in range
  `MBE_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full)
  `MBE_ASSERT_NOW(a_no_pop_empty, q_pop, !q_stat.empty)
  `MBE_ASSERT_NOW(a_count_range, out_valid, (iter_count != '0) && ((iter_count <= cfg.max_iter) || (iter_count == COUNT_W'(1))))
  `MBE_ASSERT_NEXT(a_pop_starts, q_pop, !q_stat.full)

endmodule

[rtl/core/mbe_front.sv]
// Front end: accepts pixel items and forms the complex point c.
// Two registered stages (index times step, then origin add and scaling); uses mbe_pkg.
module mbe_front #(
  parameter int IMAGE_SIZE = 1024,
  parameter int FRAC_BITS  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mbe_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mbe_pkg::PIX_W-1:0]        pixel_col,
  input  logic [mbe_pkg::PIX_W-1:0]        pixel_row,
  input  mbe_pkg::q_stat_t                 q_stat,
  output logic                             q_push,
  output logic signed [mbe_pkg::INT_W+FRAC_BITS-1:0] push_cx,
  output logic signed [mbe_pkg::INT_W+FRAC_BITS-1:0] push_cy,
  output mbe_pkg::pix_t                    push_pix
);
  import mbe_pkg::*;

  localparam int W       = INT_W + FRAC_BITS;
  localparam int IDX_W   = (IMAGE_SIZE > (1 << PIX_W)) ? PIX_W : $clog2(IMAGE_SIZE);
  localparam int PR_W    = IDX_W + STEP_W;
  localparam int CW      = PR_W + 2;
  localparam int CE      = (CW + 12 > W) ? CW + 12 : W;
  localparam int SH_L    = (FRAC_BITS >= Q28) ? FRAC_BITS - Q28 : 0;
  localparam int SH_R    = (FRAC_BITS >= Q28) ? 0 : Q28 - FRAC_BITS;
  localparam int unsigned IDX_MAX = IMAGE_SIZE - 1;

  logic              valid_a, valid_b;
  logic              a_ready, b_ready;
  logic [IDX_W-1:0]  col_sat, row_sat;
  logic [PR_W-1:0]   prod_x, prod_y;
  pix_t              pix_a, pix_b;
  logic signed [W-1:0]  cx, cy;
  logic signed [CW-1:0] c28x, c28y;
  logic signed [CE-1:0] cex, cey, cfx, cfy;

  // Handshake: each stage advances when the one after it has room
  always_comb begin
    b_ready  = !valid_b || !q_stat.full;
    a_ready  = !valid_a || b_ready;
    in_stall = !a_ready;
    q_push   = valid_b && !q_stat.full;
  end

  // Clamp indices that lie past the image edge
  always_comb begin
    col_sat = (32'(pixel_col) > IDX_MAX) ? IDX_W'(IDX_MAX) : IDX_W'(pixel_col);
    row_sat = (32'(pixel_row) > IDX_MAX) ? IDX_W'(IDX_MAX) : IDX_W'(pixel_row);
  end

  // Stage A: index times step
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (a_ready) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      prod_x    <= PR_W'(col_sat) * PR_W'(cfg.x_step);
      prod_y    <= PR_W'(row_sat) * PR_W'(cfg.y_step);
      pix_a.col <= pixel_col;
      pix_a.row <= pixel_row;
    end
  end

  // Add origin in Q4.28, then rescale to the working fraction width
  always_comb begin
    c28x = {{(CW-32){cfg.x_origin[31]}}, cfg.x_origin} + {{(CW-PR_W){1'b0}}, prod_x};
    c28y = {{(CW-32){cfg.y_origin[31]}}, cfg.y_origin} + {{(CW-PR_W){1'b0}}, prod_y};
    cex  = {{(CE-CW){c28x[CW-1]}}, c28x};
    cey  = {{(CE-CW){c28y[CW-1]}}, c28y};
    cfx  = (cex <<< SH_L) >>> SH_R;
    cfy  = (cey <<< SH_L) >>> SH_R;
  end

  // Stage B: hold c until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (b_ready) begin
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_a && b_ready) begin
      cx    <= cfx[W-1:0];
      cy    <= cfy[W-1:0];
      pix_b <= pix_a;
    end
  end

  assign push_cx  = cx;
  assign push_cy  = cy;
  assign push_pix = pix_b;

endmodule

[rtl/core/mbe_queue.sv]
// Short first-in first-out queue between the front and back ends.
// Register-based storage, one push and one pop per cycle; uses mbe_pkg.
module mbe_queue #(
  parameter int DEPTH = 4,
  parameter int DW    = 116
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [DW-1:0]    push_data,
  input  logic             pop,
  output logic [DW-1:0]    pop_data,
  output mbe_pkg::q_stat_t q_stat
);
  import mbe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  // Status flags
  always_comb begin
    q_stat.full  = (count == CNT_W'(DEPTH));
    q_stat.empty = (count == '0);
    pop_data     = entries[rd_ptr];
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store an item
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/core/mbe_iter.sv]
// Back end: iterates z = z*z + c for one point and holds the result item.
// Six-step sequencer around split-operand multipliers; uses mbe_pkg.
module mbe_iter #(
  parameter int FRAC_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mbe_pkg::cfg_t                    cfg,
  input  mbe_pkg::q_stat_t                 q_stat,
  output logic                             q_pop,
  input  logic signed [mbe_pkg::INT_W+FRAC_BITS-1:0] pop_cx,
  input  logic signed [mbe_pkg::INT_W+FRAC_BITS-1:0] pop_cy,
  input  mbe_pkg::pix_t                    pop_pix,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mbe_pkg::COUNT_W-1:0]      iter_count,
  output logic [mbe_pkg::PIX_W-1:0]        out_col,
  output logic [mbe_pkg::PIX_W-1:0]        out_row
);
  import mbe_pkg::*;

  localparam int W  = INT_W + FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int H  = (W + 1) / 2;

  iter_state_t state, state_next;

  logic signed [W-1:0]  cx, cy, x, y;
  pix_t                 pix;
  logic [W-1:0]         ax, ay;
  logic                 neg_xy;
  logic [2*H-1:0]       px_ll, px_lh, px_hh, py_ll, py_lh, py_hh;
  logic [2*H-1:0]       pm_ll, pm_lh, pm_hl, pm_hh;
  logic [2*H:0]         mid_x, mid_y, mid_xy;
  logic [PW-1:0]        x2, y2, xy;
  logic signed [PW:0]   diff;
  logic signed [PW+1:0] pxy;
  logic [COUNT_W-1:0]   iter, count;
  logic                 first;

  logic                 res_load;
  logic                 res_valid;
  logic [COUNT_W-1:0]   res_count;
  pix_t                 res_pix;

  logic signed [PW:0]   diff_c;
  logic signed [PW+1:0] pxy_c;
  logic [PW+1:0]        two_xy;
  logic [PW:0]          sum_c, lim_c;
  logic                 esc;
  logic [COUNT_W:0]     iter_inc;
  logic                 last;
  logic signed [PW:0]   dsh;
  logic signed [PW+1:0] psh;
  logic [W-1:0]         x_c, y_c, ax_c, ay_c;
  logic [H-1:0]         xl, xh, yl, yh;
  logic [4*H-1:0]       x2_c, y2_c, xy_c;

  // Squared magnitude test, difference of squares, doubled cross term and iteration limit test
  always_comb begin
    sum_c    = {1'b0, x2} + {1'b0, y2};
    lim_c    = (PW+1)'(cfg.bailout_sq) << (2 * FRAC_BITS);
    esc      = sum_c > lim_c;
    diff_c   = $signed({1'b0, x2}) - $signed({1'b0, y2});
    two_xy   = {1'b0, xy, 1'b0};
    pxy_c    = neg_xy ? -$signed(two_xy) : $signed(two_xy);
    iter_inc = {1'b0, iter} + 1'b1;
    last     = iter_inc >= {1'b0, cfg.max_iter};
  end

  // Floor scaling back to the working format, then add c; absolute values of x and y
  always_comb begin
    dsh  = diff >>> FRAC_BITS;
    psh  = pxy >>> FRAC_BITS;
    x_c  = dsh[W-1:0] + cx;
    y_c  = psh[W-1:0] + cy;
    ax_c = x[W-1] ? $unsigned(-x) : $unsigned(x);
    ay_c = y[W-1] ? $unsigned(-y) : $unsigned(y);
  end

  // Operand halves and recombined products
  always_comb begin
    xl   = ax[H-1:0];
    xh   = H'(ax[W-1:H]);
    yl   = ay[H-1:0];
    yh   = H'(ay[W-1:H]);
    x2_c = {px_hh, px_ll} + ((4*H)'(mid_x) << H);
    y2_c = {py_hh, py_ll} + ((4*H)'(mid_y) << H);
    xy_c = {pm_hh, pm_ll} + ((4*H)'(mid_xy) << H);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!q_stat.empty) begin
          state_next = (cfg.max_iter <= COUNT_W'(1)) ? S_DONE : S_DIFF;
        end
      end
      S_DIFF: begin
        if (first) begin
          state_next = S_NEXT;
        end else if (esc || last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: state_next = S_MAG;
      S_MAG:  state_next = S_MUL;
      S_MUL:  state_next = S_MID;
      S_MID:  state_next = S_PROD;
      S_PROD: state_next = S_DIFF;
      S_DONE: begin
        if (res_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    res_load = 1'b0;
    unique case (state)
      S_IDLE:  q_pop    = !q_stat.empty;
      S_DONE:  res_load = !res_valid || !out_stall;
      default: begin
        q_pop    = 1'b0;
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Iteration datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          cx     <= pop_cx;
          cy     <= pop_cy;
          pix    <= pop_pix;
          x2     <= '0;
          y2     <= '0;
          xy     <= '0;
          neg_xy <= 1'b0;
          first  <= 1'b1;
          iter   <= COUNT_W'(1);
          count  <= COUNT_W'(1);
        end
      end
      S_DIFF: begin
        diff  <= diff_c;
        pxy   <= pxy_c;
        first <= 1'b0;
        if (!first) begin
          if (esc) begin
            count <= iter;
          end else if (last) begin
            count <= iter_inc[COUNT_W-1:0];
          end else begin
            iter <= iter_inc[COUNT_W-1:0];
          end
        end
      end
      S_NEXT: begin
        x <= x_c;
        y <= y_c;
      end
      S_MAG: begin
        ax     <= ax_c;
        ay     <= ay_c;
        neg_xy <= x[W-1] ^ y[W-1];
      end
      S_MUL: begin
        px_ll <= (2*H)'(xl) * (2*H)'(xl);
        px_lh <= (2*H)'(xl) * (2*H)'(xh);
        px_hh <= (2*H)'(xh) * (2*H)'(xh);
        py_ll <= (2*H)'(yl) * (2*H)'(yl);
        py_lh <= (2*H)'(yl) * (2*H)'(yh);
        py_hh <= (2*H)'(yh) * (2*H)'(yh);
        pm_ll <= (2*H)'(xl) * (2*H)'(yl);
        pm_lh <= (2*H)'(xl) * (2*H)'(yh);
        pm_hl <= (2*H)'(xh) * (2*H)'(yl);
        pm_hh <= (2*H)'(xh) * (2*H)'(yh);
      end
      S_MID: begin
        mid_x  <= {px_lh, 1'b0};
        mid_y  <= {py_lh, 1'b0};
        mid_xy <= {1'b0, pm_lh} + {1'b0, pm_hl};
      end
      S_PROD: begin
        x2 <= x2_c[PW-1:0];
        y2 <= y2_c[PW-1:0];
        xy <= xy_c[PW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_count <= count;
      res_pix   <= pix;
    end
  end

  assign out_valid  = res_valid;
  assign iter_count = res_count;
  assign out_col    = res_pix.col;
  assign out_row    = res_pix.row;

endmodule

[verif/tb.sv]
// Testbench for the Mandelbrot escape-time block: pixels go in, escape counts come out.
// Predicts each count with an exact fixed-point iteration and checks results in order.
// Depends on mbe_pkg and the mandelbrot_escape_iteration RTL.
module tb;
  import mbe_pkg::*;

  localparam int IMG  = 1024;
  localparam int FRAC = 32;

  // Register slots with no register behind them
  localparam logic [CIDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CIDX_W-1:0] REG_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   row;
  } escape_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PIX_W-1:0]    pixel_col = '0;
  logic [PIX_W-1:0]    pixel_row = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [COUNT_W-1:0]  iter_count;
  logic [PIX_W-1:0]    out_col;
  logic [PIX_W-1:0]    out_row;

  // Current view as the block should hold it
  cfg_t view = '{x_origin: X_ORIGIN_RST, x_step: X_STEP_RST, y_origin: Y_ORIGIN_RST,
                 y_step: Y_STEP_RST, max_iter: MAX_ITER_RST, bailout_sq: BAILOUT_SQ_RST};

  pix_t    pix_q[$];
  escape_t escape_q[$];
  pix_t    next_pix;
  escape_t want;
  int      errors = 0;
  int      send_pct = 15;
  int      stall_pct = 73;
  int      idle_cycles = 0;
  int      pixels_taken = 0;
  int      views_run = 0;
  logic [COUNT_W-1:0] count_lo = '1;
  logic [COUNT_W-1:0] count_hi = '0;

  mandelbrot_escape_iteration #(.IMAGE_SIZE(IMG), .FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_col(pixel_col), .pixel_row(pixel_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .iter_count(iter_count), .out_col(out_col), .out_row(out_row)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Iterate z = z*z + c exactly and return the escape count for one pixel
  function automatic escape_t escape_count(input pix_t p);
    logic signed [127:0] cx, cy, x, y, x2, y2, y_next, lim;
    longint unsigned col_sat, row_sat;
    int unsigned n;
    bit escaped;
    col_sat = (p.col > IMG - 1) ? IMG - 1 : p.col;
    row_sat = (p.row > IMG - 1) ? IMG - 1 : p.row;
    cx = longint'($signed(view.x_origin)) + longint'(col_sat * view.x_step);
    cy = longint'($signed(view.y_origin)) + longint'(row_sat * view.y_step);
    cx = cx <<< (FRAC - Q28);
    cy = cy <<< (FRAC - Q28);
    lim = view.bailout_sq;
    lim = lim <<< (2 * FRAC);
    x = 0;
    y = 0;
    x2 = 0;
    y2 = 0;
    n = 1;
    escaped = 1'b0;
    while (n < view.max_iter && !escaped) begin
      y_next = (((x * y) <<< 1) >>> FRAC) + cy;
      x = ((x2 - y2) >>> FRAC) + cx;
      y = y_next;
      x2 = x * x;
      y2 = y * y;
      if (x2 + y2 > lim) escaped = 1'b1;
      else n++;
    end
    escape_count.count = n[COUNT_W-1:0];
    escape_count.col = p.col;
    escape_count.row = p.row;
  endfunction

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  // Write one register and track it in the view
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_X_ORIGIN:   view.x_origin = data;
      REG_X_STEP:     view.x_step = data[STEP_W-1:0];
      REG_Y_ORIGIN:   view.y_origin = data;
      REG_Y_STEP:     view.y_step = data[STEP_W-1:0];
      REG_MAX_ITER:   view.max_iter = data[COUNT_W-1:0];
      REG_BAILOUT_SQ: view.bailout_sq = data[BAIL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
    views_run++;
  endtask

  // Wait until every queued item has been taken and answered, then let the block settle
  task automatic drain();
    do @(negedge clk); while (pix_q.size() != 0 || in_valid || escape_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_pixel(input int c, input int r);
    pix_q.push_back(pix_t'({PIX_W'(c), PIX_W'(r)}));
  endtask

  // Driver: predict each item taken, then present the next one or hold
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        escape_q.push_back(escape_count(pix_t'({pixel_col, pixel_row})));
        pixels_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pix_q.size() != 0 && $urandom_range(99) >= send_pct) begin
          next_pix = pix_q.pop_front();
          in_valid  <= 1'b1;
          pixel_col <= next_pix.col;
          pixel_row <= next_pix.row;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result item with the oldest prediction, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (escape_q.size() == 0) begin
          report($sformatf("result with nothing pending: col %0d row %0d count %0d",
                           out_col, out_row, iter_count));
        end else begin
          want = escape_q.pop_front();
          if (iter_count !== want.count)
            report($sformatf("count %0d, predicted %0d for col %0d row %0d",
                             iter_count, want.count, want.col, want.row));
          if (out_col !== want.col)
            report($sformatf("col %0d, predicted %0d", out_col, want.col));
          if (out_row !== want.row)
            report($sformatf("row %0d, predicted %0d", out_row, want.row));
          if (want.count < count_lo) count_lo = want.count;
          if (want.count > count_hi) count_hi = want.count;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: give up when nothing moves for far longer than one pixel can take
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 32 * int'(view.max_iter) + 4000) begin
        $display("timeout: no item moved for %0d cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int ph, k;
    logic [CFG_W-1:0] d;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Default view: corners, bit patterns, points inside and outside the set
    queue_pixel(0, 0);
    queue_pixel(IMG - 1, IMG - 1);
    queue_pixel(0, IMG - 1);
    queue_pixel(IMG - 1, 0);
    queue_pixel(749, 500);
    queue_pixel(682, 341);
    queue_pixel(341, 682);
    queue_pixel(600, 500);
    drain();

    // Zero limit and zero bailout; poke the unused register slots
    write_reg(REG_MAX_ITER, 32'h0000_0000);
    write_reg(REG_BAILOUT_SQ, 32'h0000_0000);
    write_reg(REG_UNUSED_6, $urandom());
    write_reg(REG_UNUSED_7, $urandom());
    close_writes();
    queue_pixel(5, 5);
    queue_pixel(IMG - 1, IMG - 1);
    drain();

    // Limit of one, with junk in the upper data bits
    write_reg(REG_MAX_ITER, 32'hFFFF_0001);
    close_writes();
    queue_pixel(749, 500);
    queue_pixel(0, 0);
    drain();

    // Extreme origins and steps: c far outside the Q4.28 range
    write_reg(REG_MAX_ITER, 32'h0000_0002);
    write_reg(REG_BAILOUT_SQ, 32'h0000_0003);
    write_reg(REG_X_ORIGIN, 32'h7FFF_FFFF);
    write_reg(REG_X_STEP, 32'hFFFF_FFFF);
    write_reg(REG_Y_ORIGIN, 32'h8000_0000);
    write_reg(REG_Y_STEP, 32'h0000_0000);
    close_writes();
    queue_pixel(IMG - 1, IMG - 1);
    queue_pixel(0, 0);
    queue_pixel(IMG - 1, 0);
    drain();

    // Full limit and full bailout: c = 0 never escapes
    write_reg(REG_X_ORIGIN, 32'h0000_0000);
    write_reg(REG_Y_ORIGIN, 32'h0000_0000);
    write_reg(REG_X_STEP, 32'h0010_0000);
    write_reg(REG_Y_STEP, 32'h0010_0000);
    write_reg(REG_MAX_ITER, 32'h0000_FFFF);
    write_reg(REG_BAILOUT_SQ, 32'hFFFF_FFFF);
    close_writes();
    queue_pixel(0, 0);
    queue_pixel(IMG - 1, IMG - 1);
    queue_pixel(IMG - 1, 0);
    queue_pixel(512, 0);
    drain();

    // Random views, each swept with random pixels
    for (ph = 0; ph < 9; ph++) begin
      if ($urandom_range(3) == 0) d = $urandom();
      else d = 32'($urandom_range(32'h3000_0000, 0)) - 32'd805306368;
      write_reg(REG_X_ORIGIN, d);
      if ($urandom_range(3) == 0) d = $urandom();
      else d = 32'($urandom_range(32'h2000_0000, 0)) - 32'd536870912;
      write_reg(REG_Y_ORIGIN, d);
      if ($urandom_range(5) == 0) d = $urandom();
      else d = $urandom_range(32'h0020_0000, 32'h0001_0000);
      write_reg(REG_X_STEP, d);
      if ($urandom_range(5) == 0) d = $urandom();
      else d = $urandom_range(32'h0020_0000, 32'h0001_0000);
      write_reg(REG_Y_STEP, d);
      write_reg(REG_MAX_ITER, {16'($urandom()), 16'($urandom_range(100, 2))});
      if ($urandom_range(3) == 0) d = {18'($urandom()), 14'($urandom_range(16383, 0))};
      else d = {18'($urandom()), 14'($urandom_range(10000, 4))};
      write_reg(REG_BAILOUT_SQ, d);
      close_writes();

      // Sender idles lightly first, then the receiver, then neither
      case (ph / 3)
        0: begin
          send_pct = 15;
          stall_pct = 73;
        end
        1: begin
          send_pct = 73;
          stall_pct = 15;
        end
        default: begin
          send_pct = 0;
          stall_pct = 0;
        end
      endcase

      for (k = 0; k < 110; k++) queue_pixel($urandom_range(IMG - 1), $urandom_range(IMG - 1));
      drain();
    end

    repeat (40) @(posedge clk);
    if (escape_q.size() != 0)
      report($sformatf("%0d predicted results never arrived", escape_q.size()));
    $display("Swept %0d pixels over %0d register views", pixels_taken, views_run + 1);
    $display("Escape counts seen ranged from %0d to %0d", count_lo, count_hi);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[mandelbrot_escape_iteration.f]
+incdir+rtl/core
rtl/core/mbe_pkg.sv
rtl/core/mbe_front.sv
rtl/core/mbe_queue.sv
rtl/core/mbe_iter.sv
rtl/core/mandelbrot_escape_iteration.sv
verif/tb.sv
